// ===== sv/hsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_pkg - shared types and constants of the heading steering PID
// Fixed widths, angle constants in 0.01 degree units, register indexes,
// turn modes and the half-turn wrap used on heading differences.
// ----------------------------------------------------------------------------
package hsp_pkg;

	// wide signed heading difference, covers target minus current
	typedef logic signed [18:0] hdiff_t;
	// clamped heading error, +-6000
	typedef logic signed [13:0] herr_t;
	// wrapped heading rate, +-18000
	typedef logic signed [15:0] hrate_t;
	typedef logic signed [31:0] integ_t;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [14:0] integ_limit;
	} mix_cfg_t;

	typedef enum logic [2:0] {
		CFG_GAIN_P       = 3'd0,
		CFG_GAIN_I       = 3'd1,
		CFG_GAIN_D       = 3'd2,
		CFG_TURN_MODE    = 3'd3,
		CFG_INTEG_CUTOFF = 3'd4,
		CFG_INTEG_LIMIT  = 3'd5
	} cfg_idx_t;

	localparam logic [1:0] TURN_CLOSEST = 2'd0;
	localparam logic [1:0] TURN_LEFT    = 2'd1;
	localparam logic [1:0] TURN_RIGHT   = 2'd2;

	localparam logic [15:0] RST_GAIN_P       = 16'd256;
	localparam logic [15:0] RST_GAIN_I       = 16'd0;
	localparam logic [15:0] RST_GAIN_D       = 16'd0;
	localparam logic [12:0] RST_INTEG_CUTOFF = 13'd6000;
	localparam logic [14:0] RST_INTEG_LIMIT  = 15'd1000;

	localparam hdiff_t HALF_TURN = 19'sd18000;
	localparam hdiff_t FULL_TURN = 19'sd36000;
	localparam hdiff_t BAND_EDGE = 19'sd2000;
	localparam hdiff_t ERR_CLAMP = 19'sd6000;

	// dead zone of 0.2 degree, in Q.8 of 0.01 degree
	localparam logic signed [34:0] DEAD_ZONE_Q8 = 35'sd5120;
	localparam logic signed [34:0] OUT_MAX      = 35'sd32767;
	localparam logic signed [34:0] OUT_MIN      = -35'sd32768;

	// fold into +-180 degrees, at most two turns each way
	function automatic hdiff_t wrap_half(input hdiff_t v);
		hdiff_t r;
		r = v;
		if (r > HALF_TURN) r = r - FULL_TURN;
		if (r > HALF_TURN) r = r - FULL_TURN;
		if (r < -HALF_TURN) r = r + FULL_TURN;
		if (r < -HALF_TURN) r = r + FULL_TURN;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/hsp_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_mix - PID term mixing
// Scales error, rate and integral by their Q8.8 gains, clamps the integral
// term, applies the dead zone and saturates to a 16-bit command.
// ----------------------------------------------------------------------------
module hsp_mix (
	input  hsp_pkg::mix_cfg_t cfg,
	input  hsp_pkg::herr_t    err,
	input  hsp_pkg::hrate_t   rate,
	input  hsp_pkg::integ_t   integ,
	output logic signed [15:0] steer
);
	import hsp_pkg::*;

	logic signed [16:0] gp_s, gi_s, gd_s;
	logic signed [48:0] prod_i;
	logic signed [40:0] iterm_raw;
	logic signed [40:0] lim_w;
	logic signed [15:0] iterm;
	logic signed [30:0] prod_p;
	logic signed [32:0] prod_d;
	logic signed [34:0] sum;
	logic signed [34:0] quo;

	assign gp_s = $signed({1'b0, cfg.gain_p});
	assign gi_s = $signed({1'b0, cfg.gain_i});
	assign gd_s = $signed({1'b0, cfg.gain_d});

	assign prod_i    = integ * gi_s;
	assign iterm_raw = 41'(prod_i >>> 8);
	assign lim_w     = $signed({26'd0, cfg.integ_limit});

	always_comb begin
		if (iterm_raw > lim_w) begin
			iterm = 16'(lim_w);
		end else if (iterm_raw < -lim_w) begin
			iterm = 16'(-lim_w);
		end else begin
			iterm = 16'(iterm_raw);
		end
	end

	assign prod_p = err * gp_s;
	assign prod_d = rate * gd_s;
	assign sum    = 35'(prod_p) + 35'(prod_d) - (35'(iterm) <<< 8);
	assign quo    = sum >>> 8;

	always_comb begin
		if (sum > -DEAD_ZONE_Q8 && sum < DEAD_ZONE_Q8) begin
			steer = '0;
		end else if (quo > OUT_MAX) begin
			steer = 16'(OUT_MAX);
		end else if (quo < OUT_MIN) begin
			steer = 16'(OUT_MIN);
		end else begin
			steer = 16'(quo);
		end
	end

endmodule
`default_nettype wire

// ===== sv/heading_steering_pid.sv =====
`default_nettype none
// An accepted input beat passes stage 1, stage 2 and the stage 3 output register to its steer_angle beat.
// Throughput: one beat per cycle; the three stages advance together and hold
// only while the output register is full and out_stall is high.
// Reset (arst_n low, asynchronous): clears stage valids, prev heading and
// the error integral, and loads the registers with their documented defaults.
// ----------------------------------------------------------------------------
// heading_steering_pid - PID heading controller for steering
// Wraps and shapes the heading error, tracks an error integral and the
// heading rate, and mixes the three terms into a saturated steering command.
// ----------------------------------------------------------------------------
module heading_steering_pid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [16:0]  target_heading,
	input  logic [15:0]         current_heading,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  steer_angle,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import hsp_pkg::*;

	// configuration registers
	logic [15:0] gain_p_q, gain_i_q, gain_d_q;
	logic [1:0]  turn_mode_q;
	logic [12:0] integ_cutoff_q;
	logic [14:0] integ_limit_q;

	// controller state
	logic [15:0] prev_heading_q;
	integ_t      error_integral_q;

	// pipeline
	logic               adv;
	logic               valid_s1, valid_s2, valid_s3;
	logic signed [16:0] target_s1;
	logic [15:0]        cur_s1;
	herr_t              err_s2;
	hrate_t             rate_s2;
	integ_t             integ_s2;
	logic signed [15:0] steer_s3;

	// stage 1 combinational
	hdiff_t             tgt_w, cur_w, prev_w;
	hdiff_t             err_w, err_turn, rate_w;
	herr_t              err_c;
	logic signed [14:0] err_x, cut_w;
	logic               in_band;
	logic signed [32:0] integ_diff;
	integ_t             integ_nxt;

	mix_cfg_t           mix_cfg;
	logic signed [15:0] steer_c;

	// Advance every stage unless a finished beat sits unaccepted at the output.
	assign adv      = !(valid_s3 && out_stall);
	assign in_stall = !adv;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= RST_GAIN_P;
			gain_i_q       <= RST_GAIN_I;
			gain_d_q       <= RST_GAIN_D;
			turn_mode_q    <= TURN_CLOSEST;
			integ_cutoff_q <= RST_INTEG_CUTOFF;
			integ_limit_q  <= RST_INTEG_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_P:       gain_p_q       <= cfg_data;
				CFG_GAIN_I:       gain_i_q       <= cfg_data;
				CFG_GAIN_D:       gain_d_q       <= cfg_data;
				CFG_TURN_MODE:    turn_mode_q    <= cfg_data[1:0];
				CFG_INTEG_CUTOFF: integ_cutoff_q <= cfg_data[12:0];
				CFG_INTEG_LIMIT:  integ_limit_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Stage 1: register the input beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			target_s1 <= target_heading;
			cur_s1    <= current_heading;
		end
	end

	// Heading error: wrap, take the sign flip, then let the turn mode force
	// the long way round once the error is strictly past the 20 degree band.
	assign tgt_w  = {{2{target_s1[16]}}, target_s1};
	assign cur_w  = {3'd0, cur_s1};
	assign prev_w = {3'd0, prev_heading_q};
	assign err_w  = -wrap_half(tgt_w - cur_w);
	assign rate_w = wrap_half(cur_w - prev_w);

	always_comb begin
		err_turn = err_w;
		if (err_w > -BAND_EDGE && err_w < BAND_EDGE) begin
			err_turn = err_w;
		end else if (turn_mode_q == TURN_LEFT && err_w < -BAND_EDGE) begin
			err_turn = err_w + FULL_TURN;
		end else if (turn_mode_q == TURN_RIGHT && err_w > BAND_EDGE) begin
			err_turn = err_w - FULL_TURN;
		end
	end

	// Clamp the error to +-60 degrees.
	always_comb begin
		if (err_turn > ERR_CLAMP) begin
			err_c = 14'(ERR_CLAMP);
		end else if (err_turn < -ERR_CLAMP) begin
			err_c = 14'(-ERR_CLAMP);
		end else begin
			err_c = 14'(err_turn);
		end
	end

	// Integrate only inside the cutoff band; saturate at signed 32 bits.
	assign err_x      = {err_c[13], err_c};
	assign cut_w      = $signed({2'd0, integ_cutoff_q});
	assign in_band    = (err_x < cut_w) && (err_x > -cut_w);
	assign integ_diff = {error_integral_q[31], error_integral_q} - 33'(err_c);

	always_comb begin
		if (!in_band) begin
			integ_nxt = error_integral_q;
		end else if (integ_diff[32] != integ_diff[31]) begin
			integ_nxt = integ_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			integ_nxt = integ_diff[31:0];
		end
	end

	// Stage 2: commit state and hand error, rate and integral to the mixer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2         <= 1'b0;
			prev_heading_q   <= '0;
			error_integral_q <= '0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				prev_heading_q   <= cur_s1;
				error_integral_q <= integ_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			err_s2   <= err_c;
			rate_s2  <= 16'(rate_w);
			integ_s2 <= integ_nxt;
		end
	end

	assign mix_cfg = '{
		gain_p:      gain_p_q,
		gain_i:      gain_i_q,
		gain_d:      gain_d_q,
		integ_limit: integ_limit_q
	};

	hsp_mix u_mix (
		.cfg   (mix_cfg),
		.err   (err_s2),
		.rate  (rate_s2),
		.integ (integ_s2),
		.steer (steer_c)
	);

	// Stage 3: output register; hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			steer_s3 <= steer_c;
		end
	end

	assign out_valid   = valid_s3;
	assign steer_angle = steer_s3;

endmodule
`default_nettype wire

// ===== sv/hsp_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_chk - port checker for the heading steering PID
// Watches handshakes, pipeline latency and the dead zone on the outputs.
// ----------------------------------------------------------------------------
module hsp_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] steer_angle
);

	// a stalled output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(steer_angle))
		else $error("output beat changed while stalled");

	// input side backs up only behind a held output beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output beat");

	// an accepted beat shows up at the output when no stall holds the pipeline in between
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
		else $error("result beat missing after three cycles");

	// nothing inside the 0.2 degree dead zone except zero
	a_dead_zone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> steer_angle == 16'sd0 || steer_angle >= 16'sd20 ||
			steer_angle <= -16'sd20)
		else $error("steer command inside dead zone");

endmodule

bind heading_steering_pid hsp_chk u_hsp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.steer_angle (steer_angle)
);
`default_nettype wire

// ===== verif/tb_heading_steering_pid.sv =====
// ----------------------------------------------------------------------------
// tb_heading_steering_pid - self-checking bench for the heading steering PID
// Feeds heading beats through a valid/stall driver, predicts every steering
// command in step with the accepted beats, and checks each command beat in
// order. Register settings change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_heading_steering_pid;
	import hsp_pkg::*;

	// angle constants of the predictor, 0.01 degree units
	localparam longint HALF_REV   = 18000;
	localparam longint FULL_REV   = 36000;
	localparam longint EDGE_BAND  = 2000;
	localparam longint ERR_LIMIT  = 6000;
	localparam longint DEAD_Q8    = 20 * 256;
	localparam longint STEER_MAX  = 32767;
	localparam longint STEER_MIN  = -32768;
	localparam longint INTEG_MAX  = 64'sd2147483647;
	localparam longint INTEG_MIN  = -64'sd2147483648;

	// turn mode code with no meaning of its own (acts as closest)
	localparam logic [1:0] TURN_SPARE = 2'd3;
	// register indexes past the end of the map
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	localparam int IDLE_PCT    = 19;
	localparam int DRAIN_WAIT  = 10;
	localparam int CYCLE_LIMIT = 2_000_000;
	// beats per random phase
	localparam int PHASE_BEATS = 45;
	// constant-error beats sent back to back with no idling
	localparam int STEADY_BEATS = 60;

	typedef struct packed {
		logic signed [16:0] target;
		logic [15:0]        current;
	} heading_beat_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [16:0] target_heading;
	logic [15:0]        current_heading;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] steer_angle;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	heading_steering_pid dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.target_heading  (target_heading),
		.current_heading (current_heading),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.steer_angle     (steer_angle),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// heading beats waiting for the driver, and commands waiting for the DUT
	heading_beat_t      heading_pending[$];
	logic signed [15:0] steer_expect[$];

	// shadow copy of the register file
	logic [15:0] gain_p_q;
	logic [15:0] gain_i_q;
	logic [15:0] gain_d_q;
	logic [1:0]  mode_q;
	logic [12:0] cutoff_q;
	logic [14:0] limit_q;

	// shadow copy of the controller state
	logic [15:0]        prev_q;
	logic signed [31:0] integ_q;

	logic   in_fire;
	bit     calm;
	int     n_queued;
	int     n_sent;
	int     n_checked;
	int     n_bad;
	int     n_writes;
	int     cycles;
	int     walk_heading;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Fold a heading difference into +-180 degrees, two turns at most each way.
	function automatic longint fold_turn(input longint v);
		longint r;
		r = v;
		if (r > HALF_REV) r = r - FULL_REV;
		if (r > HALF_REV) r = r - FULL_REV;
		if (r < -HALF_REV) r = r + FULL_REV;
		if (r < -HALF_REV) r = r + FULL_REV;
		return r;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Advance the shadow state by one accepted heading beat and return the
	// steering command it must produce.
	task automatic steer_predict(input logic signed [16:0] tgt, input logic [15:0] cur,
			output logic signed [15:0] steer);
		longint err;
		longint rate;
		longint iterm;
		longint lim;
		longint cut;
		longint mix;
		err = -fold_turn(longint'(tgt) - longint'(cur));
		// the long way round only applies strictly past the band edge
		if (err > -EDGE_BAND && err < EDGE_BAND) begin
			err = err;
		end else if (mode_q == TURN_LEFT && err < -EDGE_BAND) begin
			err = err + FULL_REV;
		end else if (mode_q == TURN_RIGHT && err > EDGE_BAND) begin
			err = err - FULL_REV;
		end
		err = clip(err, -ERR_LIMIT, ERR_LIMIT);

		rate = fold_turn(longint'(cur) - longint'(prev_q));
		prev_q = cur;

		cut = longint'(cutoff_q);
		if (err < cut && err > -cut)
			integ_q = 32'(clip(longint'(integ_q) - err, INTEG_MIN, INTEG_MAX));

		lim = longint'(limit_q);
		iterm = (longint'(integ_q) * longint'(gain_i_q)) >>> 8;
		iterm = clip(iterm, -lim, lim);

		mix = err * longint'(gain_p_q) + rate * longint'(gain_d_q) - iterm * 256;
		if (mix > -DEAD_Q8 && mix < DEAD_Q8)
			steer = '0;
		else
			steer = 16'(clip(mix >>> 8, STEER_MIN, STEER_MAX));
	endtask

	function automatic bit idle_roll();
		if (calm) return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// ------------------------------------------------------------------------
	// Input side: note each accepted beat and predict its command right away,
	// so prediction follows the exact order the DUT sees.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : accept_side
		logic signed [15:0] steer;
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			steer_predict(target_heading, current_heading, steer);
			steer_expect.push_back(steer);
			n_sent++;
		end
	end

	// ------------------------------------------------------------------------
	// Driver: change inputs on the falling edge only. A presented beat is
	// held until it is taken; a new beat or an idle gap follows after that.
	// The stall toward the output side is rolled fresh every cycle.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive_side
		heading_beat_t beat;
		out_stall <= arst_n && idle_roll();
		if (!in_valid || in_fire) begin
			if (arst_n && heading_pending.size() != 0 && !idle_roll()) begin
				beat = heading_pending.pop_front();
				in_valid        <= 1'b1;
				target_heading  <= beat.target;
				current_heading <= beat.current;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every command beat must match the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_side
		logic signed [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (steer_expect.size() == 0) begin
				$error("steer_angle beat with nothing expected: actual %0d", steer_angle);
				n_bad++;
			end else begin
				want = steer_expect.pop_front();
				n_checked++;
				if (steer_angle !== want) begin
					$error("steer_angle: expected %0d, actual %0d", want, steer_angle);
					n_bad++;
				end
			end
		end
	end

	// Watchdog: a stuck handshake ends the run as a failure.
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d commands outstanding",
				cycles, steer_expect.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic queue_item(input longint tgt, input longint cur);
		heading_beat_t beat;
		beat.target  = tgt[16:0];
		beat.current = cur[15:0];
		heading_pending.push_back(beat);
		n_queued++;
	endtask

	// Queue a beat whose heading error (before any turn forcing) is err.
	task automatic queue_err(input longint err, input longint cur);
		queue_item(cur - err, cur);
	endtask

	// Hold until every queued beat is taken and every command has come back.
	task automatic wait_drained();
		do @(negedge clk);
		while (n_sent != n_queued || steer_expect.size() != 0);
	endtask

	// Write one register; only called while the pipeline is empty.
	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_GAIN_P:       gain_p_q = val;
			CFG_GAIN_I:       gain_i_q = val;
			CFG_GAIN_D:       gain_d_q = val;
			CFG_TURN_MODE:    mode_q   = val[1:0];
			CFG_INTEG_CUTOFF: cutoff_q = val[12:0];
			CFG_INTEG_LIMIT:  limit_q  = val[14:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pick a register setting: all low, all high, or a random mix.
	task automatic settle_config(input int ph);
		logic [15:0] gp;
		logic [15:0] gi;
		logic [15:0] gd;
		logic [15:0] md;
		logic [15:0] cut;
		logic [15:0] lim;
		case (ph)
			0: begin
				gp = '0; gi = '0; gd = '0; md = 16'(TURN_CLOSEST); cut = '0; lim = '0;
			end
			1: begin
				gp = '1; gi = '1; gd = '1; md = 16'(TURN_RIGHT); cut = '1; lim = '1;
			end
			default: begin
				gp  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
				gi  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
				gd  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
				md  = 16'($urandom_range(0, 3));
				cut = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
				lim = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
			end
		endcase
		reg_write(CFG_GAIN_P, gp);
		reg_write(CFG_GAIN_I, gi);
		reg_write(CFG_GAIN_D, gd);
		reg_write(CFG_TURN_MODE, md);
		reg_write(CFG_INTEG_CUTOFF, cut);
		reg_write(CFG_INTEG_LIMIT, lim);
	endtask

	// One random heading beat. The measured heading mostly walks slowly so the
	// rate term stays meaningful; errors cluster around the band edges, the
	// error clamp, the wrap point and the dead zone; some beats use the full
	// width of both fields.
	task automatic queue_random();
		int     pick;
		longint err;
		pick = $urandom_range(99);
		if ($urandom_range(15) == 0)
			walk_heading = $urandom_range(0, 35999);
		else
			walk_heading = (walk_heading + 36000 - 300 + $urandom_range(0, 600)) % 36000;
		if (pick < 45) begin
			queue_item(longint'($urandom_range(0, 72000)) - 36000, walk_heading);
		end else if (pick < 65) begin
			case ($urandom_range(0, 7))
				0: err = 1999;
				1: err = 2000;
				2: err = 2001;
				3: err = 5999;
				4: err = 6000;
				5: err = 6001;
				6: err = 18000;
				default: err = 18001;
			endcase
			if ($urandom_range(1)) err = -err;
			queue_err(err, walk_heading);
		end else if (pick < 85) begin
			queue_err(longint'($urandom_range(0, 80)) - 40, walk_heading);
		end else begin
			queue_item(longint'($urandom_range(0, 131071)) - 65536,
				longint'($urandom_range(0, 65535)));
		end
	endtask

	initial begin : stimulus
		int k;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		target_heading  = '0;
		current_heading = '0;
		out_stall       = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_fire         = 1'b0;
		calm            = 1'b0;
		n_queued        = 0;
		n_sent          = 0;
		n_checked       = 0;
		n_bad           = 0;
		n_writes        = 0;
		cycles          = 0;
		walk_heading    = 0;

		// shadow registers and state at their reset values
		gain_p_q = RST_GAIN_P;
		gain_i_q = RST_GAIN_I;
		gain_d_q = RST_GAIN_D;
		mode_q   = TURN_CLOSEST;
		cutoff_q = RST_INTEG_CUTOFF;
		limit_q  = RST_INTEG_LIMIT;
		prev_q   = '0;
		integ_q  = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, dead zone edges and the error clamp
		queue_item(0, 0);
		queue_item(-65536, 65535);
		queue_item(65535, 0);
		queue_item(-36000, 35999);
		queue_item(36000, 0);
		queue_err(20, 100);
		queue_err(-20, 100);
		queue_err(19, 100);
		queue_err(-19, 100);
		queue_err(6001, 500);
		queue_err(-6001, 500);
		wait_drained();

		// forced left: only past the negative band edge
		reg_write(CFG_TURN_MODE, 16'(TURN_LEFT));
		queue_err(-2001, 1000);
		queue_err(-2000, 1000);
		queue_err(2000, 1000);
		wait_drained();

		// forced right: only past the positive band edge
		reg_write(CFG_TURN_MODE, 16'(TURN_RIGHT));
		queue_err(2001, 1000);
		queue_err(2000, 1000);
		queue_err(-2001, 1000);
		wait_drained();

		// the spare mode code must act as closest direction
		reg_write(CFG_TURN_MODE, 16'(TURN_SPARE));
		queue_err(2001, 1000);
		queue_err(-2001, 1000);
		wait_drained();

		// writes past the register map must change nothing
		reg_write(CFG_SPARE_LO, 16'hFFFF);
		reg_write(CFG_SPARE_HI, 16'h0000);
		queue_err(300, 0);
		queue_err(-300, 0);
		wait_drained();

		// Random: a fresh register setting per phase, draining between phases
		for (k = 0; k < 8; k++) begin
			settle_config(k);
			repeat (PHASE_BEATS) queue_random();
			wait_drained();
		end

		// Steady run: a constant error with no gaps on either side keeps the
		// integral falling every beat, then the error flips sign.
		reg_write(CFG_GAIN_P, 16'd256);
		reg_write(CFG_GAIN_I, 16'd1);
		reg_write(CFG_GAIN_D, 16'd0);
		reg_write(CFG_TURN_MODE, 16'(TURN_CLOSEST));
		reg_write(CFG_INTEG_CUTOFF, 16'd8191);
		reg_write(CFG_INTEG_LIMIT, 16'd32767);
		calm = 1'b1;
		for (k = 0; k < STEADY_BEATS; k++) begin
			while (heading_pending.size() > 256) @(negedge clk);
			queue_err(6000, 6000);
		end
		repeat (40) queue_err(-6000, 6000);
		wait_drained();
		calm = 1'b0;

		// a short random tail after the steady run, with gaps back on
		settle_config(2);
		repeat (40) queue_random();
		wait_drained();

		// let any stray beat surface before the verdict
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("covered %0d heading beats, %0d commands checked, %0d register writes,",
			n_sent, n_checked, n_writes);
		$display("turn modes, band and dead zone edges, register extremes and a gapless run");
		if (n_bad == 0 && steer_expect.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
